@@ hw/rtl/lasc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lasc_pkg;

	// Datapath of the bearing unit: operands sit near 2^60 after scaling.
	localparam int CW           = 64;
	localparam int ZW           = 28;
	localparam int CORDIC_STEPS = 27;
	localparam int ACC_FRAC     = 20;

	// Arctangent of 2^-i in 2^-20 degree, rounded.
	localparam logic signed [ZW-1:0] ATAN_DEG_TAB [CORDIC_STEPS] = '{
		28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121, 28'sd3750058,
		28'sd1876857,  28'sd938658,   28'sd469357,   28'sd234682,  28'sd117342,
		28'sd58671,    28'sd29335,    28'sd14668,    28'sd7334,    28'sd3667,
		28'sd1833,     28'sd917,      28'sd458,      28'sd229,     28'sd115,
		28'sd57,       28'sd29,       28'sd14,       28'sd7,       28'sd4,
		28'sd2,        28'sd1
	};

	// Upper clamp of the accumulated angle: 90 degrees.
	localparam logic [ZW-2:0] ZMAX = 27'(90 * (2 ** ACC_FRAC));

	// Configuration port.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 14;

	localparam logic [CFG_IW-1:0] REG_LOC_EN     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_LOC_CENTER = 3'd1;
	localparam logic [CFG_IW-1:0] REG_LOC_VIEW   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DET_CENTER = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DET_VIEW   = 3'd4;

	localparam logic signed [13:0] CENTER_RST = 14'sd0;
	localparam logic [12:0]        VIEW_RST   = 13'd5760;

	// One rotation vector moving down the cell chain.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] ang;
	} cordic_vec_t;

	// Sector settings seen by the final stage.
	typedef struct packed {
		logic               loc_en;
		logic signed [13:0] loc_center;
		logic [12:0]        loc_view;
		logic signed [13:0] det_center;
		logic [12:0]        det_view;
	} sector_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/lasc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lasc_cell #(
	parameter int SHIFT = 0,
	parameter int PW    = 57
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire lasc_pkg::cordic_vec_t up_vec,
	input  wire logic [PW-1:0]        up_pay,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output lasc_pkg::cordic_vec_t     dn_vec,
	output logic [PW-1:0]             dn_pay
);
	import lasc_pkg::*;

	logic                 valid_q;
	cordic_vec_t          vec_q;
	logic [PW-1:0]        pay_q;
	cordic_vec_t          step;
	logic signed [CW-1:0] xi, yi, x_sh, y_sh;
	logic signed [ZW-1:0] angi;

	// One vectoring rotation: drive y toward zero and accumulate the angle.
	always_comb begin
		xi   = up_vec.x;
		yi   = up_vec.y;
		angi = up_vec.ang;
		x_sh = xi >>> SHIFT;
		y_sh = yi >>> SHIFT;
		if (yi > 0) begin
			step.x   = xi + y_sh;
			step.y   = yi - x_sh;
			step.ang = angi + ATAN_DEG_TAB[SHIFT];
		end else begin
			step.x   = xi - y_sh;
			step.y   = yi + x_sh;
			step.ang = angi - ATAN_DEG_TAB[SHIFT];
		end
	end

	// The cell takes a new request when empty or when its contents move on.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			vec_q <= step;
			pay_q <= up_pay;
		end
	end

	assign dn_valid = valid_q;
	assign dn_vec   = vec_q;
	assign dn_pay   = pay_q;

endmodule

`default_nettype wire

@@ hw/rtl/lasc_verdict.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lasc_verdict #(
	parameter int COORD_BITS      = 16,
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lasc_pkg::sector_cfg_t      cfg,
	input  wire logic                       up_valid,
	output logic                            up_ready,
	input  wire lasc_pkg::cordic_vec_t      up_vec,
	input  wire logic [3*COORD_BITS+8:0]    up_pay,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [COORD_BITS-1:0]    out_x,
	output logic signed [COORD_BITS-1:0]    out_y,
	output logic signed [COORD_BITS-1:0]    out_z,
	output logic [7:0]                      out_intensity,
	output logic                            in_detection,
	output logic                            in_localization,
	output logic                            out_last
);
	import lasc_pkg::*;

	localparam int PW     = 3 * COORD_BITS + 9;
	localparam int F      = ANGLE_FRAC_BITS + 1;
	localparam int D450V  = 450 * (2 ** F);
	localparam int SW     = ($clog2(D450V) + 3 > 19) ? $clog2(D450V) + 3 : 19;
	localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

	localparam logic signed [SW-1:0] D90  = SW'(90 * (2 ** F));
	localparam logic signed [SW-1:0] D270 = SW'(270 * (2 ** F));
	localparam logic signed [SW-1:0] D360 = SW'(360 * (2 ** F));
	localparam logic signed [SW-1:0] D450 = SW'(D450V);
	localparam logic [ZW-1:0]        HALF = ZW'(2 ** (RND_SH - 1));

	logic                         valid_q;
	logic [PW-1:0]                pay_q;
	logic                         det_q, loc_q;
	logic signed [COORD_BITS-1:0] px, py;
	logic                         nz;
	logic signed [ZW-1:0]         ang;
	logic [ZW-2:0]                zc;
	logic [ZW-1:0]                zr;
	logic signed [SW-1:0]         a;
	logic signed [SW-1:0]         lc_ext, lv_ext, dc_ext, dv_ext;
	logic signed [SW-1:0]         loc_l, loc_r, det_l, det_r;
	logic                         det_hit, loc_hit;

	// Fixed per-quadrant window test; xs is the abscissa (point y).
	function automatic logic sector_hit(
		input logic                 xs_neg,
		input logic                 ys_neg,
		input logic signed [SW-1:0] av,
		input logic signed [SW-1:0] lv,
		input logic signed [SW-1:0] rv
	);
		logic hit;
		if (!xs_neg && !ys_neg) begin
			hit = (rv <= 0 && D90 + rv < av) || (lv - D270 > av && rv - D270 < av);
		end else if (xs_neg && !ys_neg) begin
			hit = (lv >= D360 && D450 - lv < av) || (D90 - rv > av && D90 - lv < av);
		end else if (xs_neg && ys_neg) begin
			hit = (lv >= D450 && lv - D450 > av) || (rv - D90 < av && lv - D90 > av);
		end else begin
			hit = (rv <= -D90 && -(D90 + rv) > av) || (D270 - lv < av && D270 - rv > av);
		end
		return hit;
	endfunction

	// Coordinates from the carried payload: {x, y, z, intensity, last}.
	assign px = up_pay[PW-1 -: COORD_BITS];
	assign py = up_pay[PW-1-COORD_BITS -: COORD_BITS];
	assign nz = (px != '0) && (py != '0);

	// Clamp the bearing to a quarter turn and round to the output grid, times two.
	always_comb begin
		ang = up_vec.ang;
		if (ang < 0) begin
			zc = '0;
		end else if (ang[ZW-2:0] > ZMAX) begin
			zc = ZMAX;
		end else begin
			zc = ang[ZW-2:0];
		end
		zr = ZW'(zc) + HALF;
		a  = $signed(SW'(zr >> RND_SH)) <<< 1;
	end

	// Sector edges: left = 2*center + view, right = 2*center - view.
	always_comb begin
		lc_ext = SW'(cfg.loc_center);
		lv_ext = $signed(SW'(cfg.loc_view));
		dc_ext = SW'(cfg.det_center);
		dv_ext = $signed(SW'(cfg.det_view));
		loc_l  = lc_ext + lc_ext + lv_ext;
		loc_r  = lc_ext + lc_ext - lv_ext;
		det_l  = dc_ext + dc_ext + dv_ext;
		det_r  = dc_ext + dc_ext - dv_ext;
		det_hit = nz && sector_hit(py[COORD_BITS-1], px[COORD_BITS-1], a, det_l, det_r);
		loc_hit = nz && cfg.loc_en
			&& sector_hit(py[COORD_BITS-1], px[COORD_BITS-1], a, loc_l, loc_r);
	end

	// Output register; it frees as soon as the result is taken.
	assign up_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			pay_q <= up_pay;
			det_q <= det_hit;
			loc_q <= loc_hit;
		end
	end

	assign out_valid       = valid_q;
	assign out_x           = pay_q[PW-1 -: COORD_BITS];
	assign out_y           = pay_q[PW-1-COORD_BITS -: COORD_BITS];
	assign out_z           = pay_q[PW-1-2*COORD_BITS -: COORD_BITS];
	assign out_intensity   = pay_q[8:1];
	assign out_last        = pay_q[0];
	assign in_detection    = det_q;
	assign in_localization = loc_q;

endmodule

`default_nettype wire

@@ hw/rtl/lidar_angular_sector_clip_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    point_x, point_y, point_z, intensity, cloud_last
// output    out_valid / out_stall  out_x, out_y, out_z, out_intensity,
//                                  in_detection, in_localization, out_last
// config    cfg_we                 cfg_index, cfg_data
//
// One point per cycle while out_stall is low; a result passes through 28 registers (27 rotation cells
// and the output register), the first loaded at the edge that takes its request.
// Reset clears every valid bit and loads the register defaults.
// out_stall holds the output register; empty cells upstream keep filling,
// so in_stall rises only once every cell holds a point.

module lidar_angular_sector_clip_core #(
	parameter int COORD_BITS      = 16,
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lasc_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [lasc_pkg::CFG_DW-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_BITS-1:0]  point_x,
	input  wire logic signed [COORD_BITS-1:0]  point_y,
	input  wire logic signed [COORD_BITS-1:0]  point_z,
	input  wire logic [7:0]                    intensity,
	input  wire logic                          cloud_last,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_BITS-1:0]       out_x,
	output logic signed [COORD_BITS-1:0]       out_y,
	output logic signed [COORD_BITS-1:0]       out_z,
	output logic [7:0]                         out_intensity,
	output logic                               in_detection,
	output logic                               in_localization,
	output logic                               out_last
);
	import lasc_pkg::*;

	localparam int PW    = 3 * COORD_BITS + 9;
	localparam int SCALE = 61 - COORD_BITS;

	sector_cfg_t         cfg_q;
	logic [COORD_BITS:0] abs_x, abs_y;

	logic                chain_valid [0:CORDIC_STEPS];
	logic                chain_ready [0:CORDIC_STEPS];
	cordic_vec_t         chain_vec   [0:CORDIC_STEPS];
	logic [PW-1:0]       chain_pay   [0:CORDIC_STEPS];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loc_en     <= 1'b1;
			cfg_q.loc_center <= CENTER_RST;
			cfg_q.loc_view   <= VIEW_RST;
			cfg_q.det_center <= CENTER_RST;
			cfg_q.det_view   <= VIEW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOC_EN:     cfg_q.loc_en     <= cfg_data[0];
				REG_LOC_CENTER: cfg_q.loc_center <= $signed(cfg_data[13:0]);
				REG_LOC_VIEW:   cfg_q.loc_view   <= cfg_data[12:0];
				REG_DET_CENTER: cfg_q.det_center <= $signed(cfg_data[13:0]);
				REG_DET_VIEW:   cfg_q.det_view   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Magnitudes, scaled so the vector starts near the top of the datapath.
	// Point y is the abscissa and point x the ordinate.
	always_comb begin
		abs_x = point_x[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({point_x[COORD_BITS-1], point_x}))
			: {1'b0, point_x};
		abs_y = point_y[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({point_y[COORD_BITS-1], point_y}))
			: {1'b0, point_y};
		chain_vec[0].x   = $signed(CW'(abs_y) << SCALE);
		chain_vec[0].y   = $signed(CW'(abs_x) << SCALE);
		chain_vec[0].ang = '0;
	end

	assign chain_valid[0] = in_valid;
	assign chain_pay[0]   = {point_x, point_y, point_z, intensity, cloud_last};
	assign in_stall       = !chain_ready[0];

	// Row of rotation cells, one shift amount each.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		lasc_cell #(
			.SHIFT (i),
			.PW    (PW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_vec   (chain_vec[i]),
			.up_pay   (chain_pay[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_vec   (chain_vec[i+1]),
			.dn_pay   (chain_pay[i+1])
		);
	end

	// Rounding, sector tests and the output register.
	lasc_verdict #(
		.COORD_BITS      (COORD_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.up_valid        (chain_valid[CORDIC_STEPS]),
		.up_ready        (chain_ready[CORDIC_STEPS]),
		.up_vec          (chain_vec[CORDIC_STEPS]),
		.up_pay          (chain_pay[CORDIC_STEPS]),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.out_intensity   (out_intensity),
		.in_detection    (in_detection),
		.in_localization (in_localization),
		.out_last        (out_last)
	);

	// An empty first cell always takes a request.
	a_first_cell_open: assert property (@(posedge clk) disable iff (!arst_n)
		!chain_valid[1] |-> !in_stall)
		else $error("input stalled while the first cell is empty");

	// A result leaving the output frees the whole row.
	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> !in_stall)
		else $error("input stalled while the output drains");

	// A point on an axis lies in no sector.
	a_axis_no_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_x == '0 || out_y == '0)) |-> (!in_detection && !in_localization))
		else $error("sector flag set for a point on an axis");

endmodule

`default_nettype wire
